/* hdl/byte_capacity_fifo_cache_defines.svh */
// Assertion macros used by the checker file
`ifndef BYTE_CAPACITY_FIFO_CACHE_DEFINES_SVH
`define BYTE_CAPACITY_FIFO_CACHE_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define BCFC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bcfc check failed");
// Next-cycle implication checked outside reset
`define BCFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bcfc check failed");
`endif

/* hdl/bcfc_pkg.sv */
// Shared types and constants of the byte capacity FIFO cache
package bcfc_pkg;
   localparam int ENTRIES = 16;
   localparam int SLOT_W = $clog2(ENTRIES);
   localparam logic [31:0] CAP_RESET = 32'd1048576;

   localparam logic [2:0] OP_LOOKUP = 3'd0;
   localparam logic [2:0] OP_INSERT = 3'd1;
   localparam logic [2:0] OP_REMOVE = 3'd2;
   localparam logic [2:0] OP_REDUCE = 3'd3;
   localparam logic [2:0] OP_EXPAND = 3'd4;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_TOO_LARGE = 2'd1;
   localparam logic [1:0] ST_DUPLICATE = 2'd2;

   localparam logic KIND_DONE = 1'b0;
   localparam logic KIND_EVICT = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_DECIDE,
      S_EVICT,
      S_INSERT,
      S_DONE,
      S_WAIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic latch_req;
      logic search;
      logic evict;
      logic insert;
      logic remove_hit;
      logic reduce_cap;
      logic expand_cap;
      logic load_done;
      logic load_evict;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] op;
      logic found;
      logic too_large;
      logic any_valid;
      logic need_evict_insert;
      logic need_evict_reduce;
   } stat_type;
endpackage

/* hdl/bcfc_ctrl.sv */
// Controller state machine of the byte capacity FIFO cache
module bcfc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              out_busy,
   input  bcfc_pkg::stat_type stat,
   output bcfc_pkg::cmd_type cmd
);
   import bcfc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch_req = 1'b1;
               state_in = S_SEARCH;
            end
         end
         // compare key against all slots, register match
         S_SEARCH: begin
            cmd.search = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            case (stat.op)
               OP_INSERT: begin
                  if (stat.found || stat.too_large) state_in = S_DONE;
                  else if (stat.any_valid && stat.need_evict_insert) state_in = S_EVICT;
                  else state_in = S_INSERT;
               end
               OP_REMOVE: begin
                  cmd.remove_hit = stat.found;
                  state_in = S_DONE;
               end
               OP_REDUCE: begin
                  cmd.reduce_cap = 1'b1;
                  state_in = S_WAIT;
               end
               OP_EXPAND: begin
                  cmd.expand_cap = 1'b1;
                  state_in = S_DONE;
               end
               default: state_in = S_DONE;
            endcase
         end
         // reduce: recheck occupancy against new capacity
         S_WAIT: begin
            if (stat.any_valid && stat.need_evict_reduce) state_in = S_EVICT;
            else state_in = S_DONE;
         end
         // issue an eviction beat once the output is free, then recheck in decide or wait
         S_EVICT: begin
            if (!out_busy) begin
               cmd.evict = 1'b1;
               cmd.load_evict = 1'b1;
               state_in = (stat.op == OP_INSERT) ? S_DECIDE : S_WAIT;
            end
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!out_busy) begin
               cmd.load_done = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

/* hdl/bcfc_dp.sv */
// Datapath of the byte capacity FIFO cache: slots, list links, counters, output register
module bcfc_dp (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic [31:0]       csr_data,
   input  logic [2:0]        req_opcode,
   input  logic [31:0]       req_key,
   input  logic [23:0]       req_amount,
   input  bcfc_pkg::cmd_type cmd,
   output bcfc_pkg::stat_type stat,
   output logic              out_busy,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [71:0]       rsp_tdata,
   output logic              rsp_tlast,
   output logic              rsp_tuser
);
   import bcfc_pkg::*;

   logic [31:0] key_mem [ENTRIES];
   logic [23:0] size_mem [ENTRIES];
   logic [SLOT_W-1:0] older_mem [ENTRIES];
   logic [SLOT_W-1:0] newer_mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [SLOT_W-1:0] newest_ff, oldest_ff;
   logic [31:0] used_ff, cap_ff;

   logic [2:0] op_ff;
   logic [31:0] key_ff;
   logic [23:0] amt_ff;
   logic found_ff;
   logic [SLOT_W-1:0] match_ff;

   logic rv_ff;
   logic [71:0] rd_ff;
   logic rlast_ff, ruser_ff;

   // combinational key match, free slot
   logic [ENTRIES-1:0] match_vec;
   logic [SLOT_W-1:0] match_idx, free_idx;
   logic free_any;
   always_comb begin
      match_idx = '0;
      free_idx = '0;
      free_any = 1'b0;
      for (int i = 0; i < ENTRIES; i++)
         match_vec[i] = valid_ff[i] && (key_mem[i] == key_ff);
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match_vec[i]) match_idx = SLOT_W'(i);
         if (!valid_ff[i]) begin
            free_idx = SLOT_W'(i);
            free_any = 1'b1;
         end
      end
   end

   // unlink target: oldest on evict, match on remove
   logic do_unlink;
   logic [SLOT_W-1:0] ul;
   assign do_unlink = cmd.evict || cmd.remove_hit;
   assign ul = cmd.evict ? oldest_ff : match_ff;

   logic [32:0] cap_room;
   assign cap_room = {1'b0, cap_ff} - {9'd0, amt_ff};
   logic [32:0] cap_sum;
   assign cap_sum = {1'b0, cap_ff} + {9'd0, amt_ff};

   assign stat.op = op_ff;
   assign stat.found = found_ff;
   assign stat.too_large = {8'd0, amt_ff} > cap_ff;
   assign stat.any_valid = |valid_ff;
   assign stat.need_evict_insert = (used_ff > cap_room[31:0]) || !free_any;
   assign stat.need_evict_reduce = used_ff > cap_ff;

   logic [31:0] used_after;
   assign used_after = do_unlink ? used_ff - {8'd0, size_mem[ul]} : used_ff;

   // completion status and hit
   logic [1:0] done_st;
   logic done_hit;
   always_comb begin
      done_st = ST_OK;
      if (op_ff == OP_INSERT) begin
         if (found_ff) done_st = ST_DUPLICATE;
         else if ({8'd0, amt_ff} > cap_ff) done_st = ST_TOO_LARGE;
      end
   end
   assign done_hit = found_ff && (op_ff == OP_LOOKUP || op_ff == OP_REMOVE);

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff <= req_opcode;
         key_ff <= req_key;
         amt_ff <= req_amount;
      end
      if (cmd.search) begin
         found_ff <= |match_vec;
         match_ff <= match_idx;
      end
      if (cmd.load_evict) rd_ff <= {5'd0, used_after, ST_OK, 1'b0, key_mem[oldest_ff]};
      if (cmd.load_done) rd_ff <= {5'd0, used_ff, done_st, done_hit, key_ff};
      if (cmd.insert) begin
         key_mem[free_idx] <= key_ff;
         size_mem[free_idx] <= amt_ff;
         newer_mem[free_idx] <= free_idx;
         if (valid_ff == '0) older_mem[free_idx] <= free_idx;
         else begin
            older_mem[free_idx] <= newest_ff;
            newer_mem[newest_ff] <= free_idx;
         end
      end
      if (do_unlink && !(oldest_ff == ul && newest_ff == ul)) begin
         if (oldest_ff != ul) newer_mem[older_mem[ul]] <= newer_mem[ul];
         if (newest_ff != ul) older_mem[newer_mem[ul]] <= older_mem[ul];
      end
      if (reset) begin
         valid_ff <= '0;
         newest_ff <= '0;
         oldest_ff <= '0;
         used_ff <= '0;
         cap_ff <= CAP_RESET;
         rv_ff <= 1'b0;
      end else if (csr_valid) begin
         valid_ff <= '0;
         newest_ff <= '0;
         oldest_ff <= '0;
         used_ff <= '0;
         cap_ff <= csr_data;
      end else begin
         // beat loads, or holds until taken
         rv_ff <= cmd.load_evict || cmd.load_done || (rv_ff && !rsp_tready);
         if (cmd.reduce_cap) cap_ff <= cap_room[32] ? 32'd0 : cap_room[31:0];
         if (cmd.expand_cap) cap_ff <= cap_sum[32] ? 32'hFFFF_FFFF : cap_sum[31:0];
         if (do_unlink) begin
            valid_ff[ul] <= 1'b0;
            used_ff <= used_after;
            if (oldest_ff == ul && newest_ff == ul) begin
               oldest_ff <= '0;
               newest_ff <= '0;
            end else begin
               if (oldest_ff == ul) oldest_ff <= newer_mem[ul];
               if (newest_ff == ul) newest_ff <= older_mem[ul];
            end
         end
         if (cmd.insert) begin
            valid_ff[free_idx] <= 1'b1;
            newest_ff <= free_idx;
            if (valid_ff == '0) oldest_ff <= free_idx;
            used_ff <= used_ff + {8'd0, amt_ff};
         end
      end
      if (cmd.load_done) rlast_ff <= 1'b1;
      if (cmd.load_evict) rlast_ff <= 1'b0;
      if (cmd.load_done) ruser_ff <= KIND_DONE;
      if (cmd.load_evict) ruser_ff <= KIND_EVICT;
   end

   assign out_busy = rv_ff && !rsp_tready;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = rd_ff;
   assign rsp_tlast = rlast_ff;
   assign rsp_tuser = ruser_ff;
endmodule

/* hdl/byte_capacity_fifo_cache.sv */
// Top level of the byte capacity FIFO cache directory
// Keeps up to 16 keyed entries of variable byte size in insertion order and
// evicts oldest-first against a byte capacity. One request at a time: a
// lookup, remove, expand or unknown opcode gives only its done beat, an
// insert or a reduce may first give up to 16 eviction beats (one slot at a
// time, walking the linked list), and the receiver may stall any beat. Each
// result beat waits in one output register; csr write reloads the capacity
// and empties the directory.
module byte_capacity_fifo_cache (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // opcode[2:0], entry_key[34:3], amount[58:35]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // result_key[31:0], hit[32], status[34:33], occupancy[66:35]
   output logic        rsp_tlast,
   output logic        rsp_tuser    // result_kind
);
   import bcfc_pkg::*;

   cmd_type cmd;
   stat_type stat;
   logic out_busy;

   assign csr_ready = 1'b1;

   bcfc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .out_busy(out_busy), .stat(stat), .cmd(cmd)
   );

   bcfc_dp u_dp (
      .clock(clock), .reset(reset), .csr_valid(csr_valid), .csr_data(csr_data),
      .req_opcode(req_tdata[2:0]), .req_key(req_tdata[34:3]),
      .req_amount(req_tdata[58:35]), .cmd(cmd), .stat(stat),
      .out_busy(out_busy), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );
endmodule

/* hdl/bcfc_checker.sv */
// Port-level checker of the byte capacity FIFO cache
`include "byte_capacity_fifo_cache_defines.svh"
module bcfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);
   `BCFC_ASSERT_IMPL(a_evict_not_last, clock, reset, rsp_tvalid && rsp_tuser, !rsp_tlast)
   `BCFC_ASSERT_IMPL(a_done_is_last, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tlast)
   `BCFC_ASSERT_IMPL(a_evict_clean, clock, reset, rsp_tvalid && rsp_tuser,
      rsp_tdata[34:32] == 3'd0)
   `BCFC_ASSERT_NEXT(a_one_req, clock, reset, req_tvalid && req_tready, !req_tready)
   `BCFC_ASSERT_IMPL(a_no_overlap, clock, reset, req_tready, !rsp_tvalid || rsp_tlast)
endmodule

bind byte_capacity_fifo_cache bcfc_checker u_bcfc_checker (.*);

/* tb/sv/byte_capacity_fifo_cache_test.sv */
// Self-checking testbench for the byte capacity FIFO cache directory
module byte_capacity_fifo_cache_test;
   import bcfc_pkg::*;

   typedef struct {
      logic        kind;
      logic [31:0] key;
      logic        hit;
      logic [1:0]  status;
      logic [31:0] occ;
      logic        last;
   } result_beat_t;

   typedef struct {
      logic [2:0]  op;
      logic [31:0] key;
      logic [23:0] amt;
      bit          typed;
      logic        hit;
      logic [1:0]  status;
   } stim_row_t;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // opcode[2:0], entry_key[34:3], amount[58:35]
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [71:0] rsp_tdata;       // result_key[31:0], hit[32], status[34:33], occupancy[66:35]
   logic        rsp_tlast;
   logic        rsp_tuser;       // result_kind

   byte_capacity_fifo_cache u_top (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // directory mirror: slot contents plus insertion order, oldest first
   logic [31:0] dir_key [ENTRIES];
   logic [23:0] dir_size [ENTRIES];
   bit          dir_valid [ENTRIES];
   int          age_order [$];
   logic [31:0] used_bytes;
   logic [31:0] capacity;

   result_beat_t pending_results [$];
   int errors = 0;
   int items_sent = 0;
   int beats_seen = 0;
   int evictions_seen = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   localparam int QUIET_LIMIT = 20000;

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   function automatic void clear_directory(input logic [31:0] cap);
      for (int i = 0; i < ENTRIES; i++) dir_valid[i] = 0;
      age_order = {};
      used_bytes = 0;
      capacity = cap;
   endfunction

   function automatic int find_slot(input logic [31:0] key);
      foreach (age_order[i])
         if (dir_key[age_order[i]] == key) return age_order[i];
      return -1;
   endfunction

   function automatic void push_beat(input logic kind, input logic [31:0] key,
                                     input logic hit, input logic [1:0] status);
      result_beat_t b;
      b.kind = kind; b.key = key; b.hit = hit; b.status = status;
      b.occ = used_bytes; b.last = (kind == KIND_DONE);
      pending_results.insert(pending_results.size(), b);
   endfunction

   function automatic void evict_oldest();
      int s;
      s = age_order.pop_front();
      dir_valid[s] = 0;
      used_bytes -= 32'(dir_size[s]);
      push_beat(KIND_EVICT, dir_key[s], 0, ST_OK);
   endfunction

   // expected beats of one accepted request
   function automatic void model_request(input logic [2:0] op, input logic [31:0] key,
                                         input logic [23:0] amt);
      int s;
      int free_slot;
      case (op)
         OP_LOOKUP: push_beat(KIND_DONE, key, find_slot(key) >= 0, ST_OK);
         OP_INSERT: begin
            if (find_slot(key) >= 0) push_beat(KIND_DONE, key, 0, ST_DUPLICATE);
            else if (32'(amt) > capacity) push_beat(KIND_DONE, key, 0, ST_TOO_LARGE);
            else begin
               while (age_order.size() > 0 &&
                      (used_bytes > capacity - 32'(amt) || age_order.size() == ENTRIES))
                  evict_oldest();
               free_slot = 0;
               while (dir_valid[free_slot]) free_slot++;
               dir_key[free_slot] = key;
               dir_size[free_slot] = amt;
               dir_valid[free_slot] = 1;
               age_order.insert(age_order.size(), free_slot);
               used_bytes += 32'(amt);
               push_beat(KIND_DONE, key, 0, ST_OK);
            end
         end
         OP_REMOVE: begin
            s = find_slot(key);
            if (s >= 0) begin
               foreach (age_order[i])
                  if (age_order[i] == s) begin
                     age_order.delete(i);
                     break;
                  end
               dir_valid[s] = 0;
               used_bytes -= 32'(dir_size[s]);
            end
            push_beat(KIND_DONE, key, s >= 0, ST_OK);
         end
         OP_REDUCE: begin
            capacity = (capacity >= 32'(amt)) ? capacity - 32'(amt) : 32'd0;
            while (age_order.size() > 0 && used_bytes > capacity) evict_oldest();
            push_beat(KIND_DONE, key, 0, ST_OK);
         end
         OP_EXPAND: begin
            if (capacity > 32'hFFFF_FFFF - 32'(amt)) capacity = 32'hFFFF_FFFF;
            else capacity += 32'(amt);
            push_beat(KIND_DONE, key, 0, ST_OK);
         end
         default: push_beat(KIND_DONE, key, 0, ST_OK);
      endcase
   endfunction

   // one request beat, with random idle cycles before it
   task automatic send_request(input logic [2:0] op, input logic [31:0] key,
                               input logic [23:0] amt);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {5'b0, amt, key, op};
      do @(posedge clock); while (!req_tready);
      model_request(op, key, amt);
      items_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 0;
      wait (pending_results.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [31:0] cap);
      drain();
      @(negedge clock);
      csr_valid <= 1;
      csr_data <= cap;
      do @(posedge clock); while (!csr_ready);
      clear_directory(cap);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // random request: small key pool for hits, sometimes full-range fields
   task automatic random_request(input logic [23:0] amt_max);
      logic [2:0]  op;
      logic [31:0] key;
      logic [23:0] amt;
      int pick;
      pick = $urandom_range(99);
      if (pick < 45) op = OP_INSERT;
      else if (pick < 65) op = OP_LOOKUP;
      else if (pick < 82) op = OP_REMOVE;
      else if (pick < 89) op = OP_REDUCE;
      else if (pick < 96) op = OP_EXPAND;
      else op = 3'($urandom_range(7, 5));
      key = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(23));
      amt = ($urandom_range(14) == 0) ? 24'($urandom) : 24'($urandom_range(amt_max));
      if (op == OP_REDUCE || op == OP_EXPAND) amt = amt >> $urandom_range(4);
      send_request(op, key, amt);
   endtask

   // receiver: random stalls, check each beat against the oldest expectation
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_seen++;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected beat key %h", rsp_tdata[31:0]));
         end else begin
            result_beat_t e;
            e = pending_results.pop_front();
            if (rsp_tuser == KIND_EVICT) evictions_seen++;
            if (rsp_tuser !== e.kind)
               report($sformatf("kind %b exp %b", rsp_tuser, e.kind));
            if (rsp_tdata[31:0] !== e.key)
               report($sformatf("key %h exp %h", rsp_tdata[31:0], e.key));
            if (rsp_tdata[32] !== e.hit)
               report($sformatf("hit %b exp %b key %h", rsp_tdata[32], e.hit, e.key));
            if (rsp_tdata[34:33] !== e.status)
               report($sformatf("status %0d exp %0d key %h", rsp_tdata[34:33],
                                e.status, e.key));
            if (rsp_tdata[66:35] !== e.occ)
               report($sformatf("occupancy %0d exp %0d key %h", rsp_tdata[66:35],
                                e.occ, e.key));
            if (rsp_tlast !== e.last)
               report($sformatf("last %b exp %b key %h", rsp_tlast, e.last, e.key));
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no progress for %0d cycles", QUIET_LIMIT);
         $display("byte_capacity_fifo_cache_test: FAIL");
         $finish;
      end
   end

   stim_row_t directed [] = '{
      '{OP_LOOKUP, 32'd0,          24'd0,        1, 1'b0, ST_OK},
      '{OP_INSERT, 32'd0,          24'd0,        1, 1'b0, ST_OK},
      '{OP_INSERT, 32'd0,          24'd5,        1, 1'b0, ST_DUPLICATE},
      '{OP_INSERT, 32'hFFFF_FFFF,  24'hFF_FFFF,  1, 1'b0, ST_TOO_LARGE},
      '{OP_LOOKUP, 32'd0,          24'hFF_FFFF,  1, 1'b1, ST_OK},
      '{OP_REMOVE, 32'd0,          24'd0,        1, 1'b1, ST_OK},
      '{OP_REMOVE, 32'd0,          24'd0,        1, 1'b0, ST_OK},
      '{OP_INSERT, 32'hFFFF_FFFF,  24'd600000,   0, 1'b0, ST_OK},
      '{OP_INSERT, 32'h5555_AAAA,  24'd300000,   0, 1'b0, ST_OK},
      '{OP_INSERT, 32'hAAAA_5555,  24'd400000,   0, 1'b0, ST_OK},
      '{OP_LOOKUP, 32'hFFFF_FFFF,  24'd0,        0, 1'b0, ST_OK},
      '{OP_REDUCE, 32'd7,          24'd500000,   0, 1'b0, ST_OK},
      '{OP_EXPAND, 32'd8,          24'hFF_FFFF,  0, 1'b0, ST_OK},
      '{3'd5,      32'h1234_5678,  24'h12_3456,  1, 1'b0, ST_OK},
      '{3'd6,      32'd1,          24'd1,        1, 1'b0, ST_OK},
      '{3'd7,      32'd2,          24'd2,        1, 1'b0, ST_OK},
      '{OP_REDUCE, 32'd9,          24'hFF_FFFF,  0, 1'b0, ST_OK},
      '{OP_REDUCE, 32'd10,         24'hFF_FFFF,  1, 1'b0, ST_OK},
      '{OP_INSERT, 32'd11,         24'd1,        1, 1'b0, ST_TOO_LARGE},
      '{OP_INSERT, 32'd12,         24'd0,        1, 1'b0, ST_OK},
      '{OP_EXPAND, 32'd13,         24'd1,        0, 1'b0, ST_OK}
   };

   int phase_idle [4] = '{0, 72, 0, 32};
   int phase_stall [4] = '{0, 0, 72, 32};
   logic [31:0] phase_cap [4] = '{32'd1000, 32'd0, 32'hFFFF_FFFF, 32'd20000};
   logic [23:0] phase_amt [4] = '{24'd300, 24'd50, 24'hFF_FFFF, 24'd4000};

   initial begin
      result_beat_t done;
      clear_directory(CAP_RESET);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed rows at the reset capacity
      foreach (directed[i]) begin
         send_request(directed[i].op, directed[i].key, directed[i].amt);
         done = pending_results[pending_results.size() - 1];
         if (directed[i].typed &&
             (done.hit !== directed[i].hit || done.status !== directed[i].status))
            report($sformatf("directed row %0d: model gives hit %b status %0d",
                             i, done.hit, done.status));
      end

      // random phases, each at its own capacity, idle and stall pattern
      for (int p = 0; p < 4; p++) begin
         write_capacity(phase_cap[p]);
         idle_pct = phase_idle[p];
         stall_pct = phase_stall[p];
         for (int n = 0; n < 40; n++) begin
            random_request(phase_amt[p]);
            if (n == 20) drain();
         end
      end
      drain();
      idle_pct = 0;
      stall_pct = 0;

      $display("%0d requests, %0d result beats, %0d evictions checked", items_sent,
               beats_seen, evictions_seen);
      $display("capacities reset/1000/0/max/20000, with sender and receiver stalls");
      if (errors == 0)
         $display("byte_capacity_fifo_cache_test: PASS");
      else
         $display("byte_capacity_fifo_cache_test: FAIL");
      $finish;
   end
endmodule
